// File: rtl/d2dt_pkg.sv
// shared constants for the double to decimal text formatter
package d2dt_pkg;

  localparam int FRACTION_DIGITS = 8;
  localparam int FRAC_SCALE      = 10 ** FRACTION_DIGITS;
  localparam int SCALE_W         = $clog2(FRAC_SCALE + 1);
  localparam int INT_W           = 32;
  localparam int FIX_FRAC_W      = 81;
  localparam int FIX_W           = FIX_FRAC_W + INT_W;
  localparam int PROD_W          = FIX_FRAC_W + SCALE_W;
  localparam int SIG_W           = 53;
  localparam int RND_W           = SIG_W + 1;
  localparam int SIG_LSB         = PROD_W - SIG_W;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int FRAC_PAD        = INT_W - SCALE_W;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_TINY     = 11'd995;
  localparam logic [10:0] EXP_HUGE     = 11'd1055;
  localparam logic [10:0] EXP_SHIFT0   = 11'd994;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

// File: rtl/d2dt_bcd.sv
// shift-and-add-3 binary to bcd converter for integer and fraction parts
module d2dt_bcd (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic [d2dt_pkg::INT_W-1:0]          number,
  input  logic [d2dt_pkg::SCALE_W-1:0]        fraction,
  output logic                                done,
  output logic [d2dt_pkg::BCD_W-1:0]          int_bcd,
  output logic [d2dt_pkg::BCD_W-1:0]          frac_bcd
);

  logic [5:0]                       cnt;
  logic                             run;
  logic [d2dt_pkg::INT_W-1:0]       isr;
  logic [d2dt_pkg::INT_W-1:0]       fsr;
  logic [d2dt_pkg::BCD_W-1:0]       iadj;
  logic [d2dt_pkg::BCD_W-1:0]       fadj;

  function automatic logic [d2dt_pkg::BCD_W-1:0] add3(input logic [d2dt_pkg::BCD_W-1:0] v);
    logic [d2dt_pkg::BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < d2dt_pkg::BCD_DIGITS; i++) begin
      if (v[i*4 +: 4] >= 4'd5) r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
    end
    return r;
  endfunction

  assign iadj = add3(int_bcd);
  assign fadj = add3(frac_bcd);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      run      <= 1'b1;
      cnt      <= '0;
      isr      <= number;
      fsr      <= {{d2dt_pkg::FRAC_PAD{1'b0}}, fraction};
      int_bcd  <= '0;
      frac_bcd <= '0;
    end else if (run) begin
      int_bcd  <= {iadj[d2dt_pkg::BCD_W-2:0], isr[d2dt_pkg::INT_W-1]};
      frac_bcd <= {fadj[d2dt_pkg::BCD_W-2:0], fsr[d2dt_pkg::INT_W-1]};
      isr      <= isr << 1;
      fsr      <= fsr << 1;
      cnt      <= cnt + 6'd1;
      if (cnt == 6'(d2dt_pkg::INT_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/double_to_decimal_text.sv
// top level: formats one binary64 value as decimal ascii text
//
//  channel  direction  beat marker            payload
//  command  in         start & !busy          value_bits
//  result   out        result_strobe          character, last, status
//
// each number is formatted before the next is accepted: a multiply-by-ten pass per
// fraction digit, a normalize, rounding, bcd conversion, then the characters, one per
// cycle. special values emit their text directly; out of range gives one flagged null.
// rst is synchronous and returns the sequencer to idle.
// results cannot be held off; each character is shown for one cycle.
module double_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value_bits,
  output logic        busy,
  output logic        result_strobe,
  output logic [7:0]  character,
  output logic        last,
  output logic        status
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_NORM, S_RND, S_FIX, S_BCD, S_CONV, S_PREP,
    S_SIGN, S_INT, S_DOT, S_FRAC, S_SPEC
  } state_t;

  typedef enum logic [1:0] {M_NAN, M_INF, M_NINF} mode_t;

  state_t                             state;
  mode_t                              mode;
  logic [63:0]                        vbits;
  logic                               neg;
  logic [d2dt_pkg::INT_W-1:0]         number;
  logic [d2dt_pkg::PROD_W-1:0]        q;
  logic [6:0]                         s;
  logic [3:0]                         k;
  logic [d2dt_pkg::SCALE_W-1:0]       frac;
  logic                               up;
  logic                               fnz;
  logic [3:0]                         nf;

  logic                               bcd_load;
  logic                               bcd_done;
  logic [d2dt_pkg::BCD_W-1:0]         int_bcd;
  logic [d2dt_pkg::BCD_W-1:0]         frac_bcd;

  logic [10:0]                        expo;
  logic [51:0]                        mant;
  logic                               sign;
  logic [5:0]                         sh;
  logic [d2dt_pkg::FIX_W-1:0]         fixed;
  logic [d2dt_pkg::INT_W-1:0]         ip;
  logic                               fnz0;
  logic                               oor;

  logic [d2dt_pkg::RND_W-1:0]         rsig;
  logic [7:0]                         t;
  logic [7:0]                         tm1;
  logic                               hb;
  logic                               lownz;
  logic [d2dt_pkg::SCALE_W-1:0]       fsh;
  logic [d2dt_pkg::SCALE_W:0]         finc;
  logic [3:0]                         nd_c;
  logic [3:0]                         nf_c;
  logic [3:0]                         dig;

  assign busy     = (state != S_IDLE);
  assign bcd_load = (state == S_BCD);

  d2dt_bcd u_bcd (
    .clk      (clk),
    .rst      (rst),
    .load     (bcd_load),
    .number   (number),
    .fraction (frac),
    .done     (bcd_done),
    .int_bcd  (int_bcd),
    .frac_bcd (frac_bcd)
  );

  always_comb begin
    expo  = vbits[62:52];
    mant  = vbits[51:0];
    sign  = vbits[63];
    sh    = 6'(expo - d2dt_pkg::EXP_SHIFT0);
    fixed = d2dt_pkg::FIX_W'({expo != 11'd0, mant}) << sh;
    if (expo < d2dt_pkg::EXP_TINY) fixed = '0;
    ip   = fixed[d2dt_pkg::FIX_W-1:d2dt_pkg::FIX_FRAC_W];
    fnz0 = |fixed[d2dt_pkg::FIX_FRAC_W-1:0];
    if (expo >= d2dt_pkg::EXP_HUGE) oor = 1'b1;
    else if (sign) oor = (ip > 32'h8000_0000) || ((ip == 32'h8000_0000) && fnz0);
    else oor = (ip > 32'h7FFF_FFFF) || ((ip == 32'h7FFF_FFFF) && fnz0);
  end

  always_comb begin
    rsig  = {1'b0, q[d2dt_pkg::PROD_W-1:d2dt_pkg::SIG_LSB]}
          + d2dt_pkg::RND_W'(q[d2dt_pkg::SIG_LSB-1]
            & (q[d2dt_pkg::SIG_LSB] | (|q[d2dt_pkg::SIG_LSB-2:0])));
    t     = 8'(d2dt_pkg::FIX_FRAC_W - d2dt_pkg::SIG_LSB) + {1'b0, s};
    tm1   = t - 8'd1;
    fsh   = d2dt_pkg::SCALE_W'(rsig >> t);
    hb    = (tm1 < 8'(d2dt_pkg::RND_W)) ? rsig[6'(tm1)] : 1'b0;
    lownz = |(rsig & ((d2dt_pkg::RND_W'(1) << tm1) - d2dt_pkg::RND_W'(1)));
    finc  = {1'b0, frac} + (d2dt_pkg::SCALE_W + 1)'(up);
  end

  always_comb begin
    nd_c = 4'd1;
    for (int i = 1; i < d2dt_pkg::BCD_DIGITS; i++) begin
      if (int_bcd[i*4 +: 4] != 4'd0) nd_c = 4'(i + 1);
    end
    nf_c = 4'd0;
    for (int i = d2dt_pkg::FRACTION_DIGITS - 1; i >= 0; i--) begin
      if (frac_bcd[i*4 +: 4] != 4'd0) nf_c = 4'(d2dt_pkg::FRACTION_DIGITS - i);
    end
    if (state == S_FRAC) dig = frac_bcd[k*4 +: 4];
    else dig = int_bcd[k*4 +: 4];
  end

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            vbits <= value_bits;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          k <= '0;
          if (expo == d2dt_pkg::EXP_ALL_ONES) begin
            if (mant != 52'd0) mode <= M_NAN;
            else if (sign) mode <= M_NINF;
            else mode <= M_INF;
            state <= S_SPEC;
          end else if (oor) begin
            result_strobe <= 1'b1;
            character     <= d2dt_pkg::CH_NUL;
            last          <= 1'b1;
            status        <= 1'b1;
            state         <= S_IDLE;
          end else begin
            neg    <= sign && (expo != 11'd0 || mant != 52'd0);
            number <= ip;
            q      <= d2dt_pkg::PROD_W'(fixed[d2dt_pkg::FIX_FRAC_W-1:0]);
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          q <= (q << 3) + (q << 1);
          k <= k + 4'd1;
          if (k == 4'(d2dt_pkg::FRACTION_DIGITS - 1)) begin
            s     <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (q == '0) begin
            frac  <= '0;
            up    <= 1'b0;
            state <= S_FIX;
          end else if (q[d2dt_pkg::PROD_W-1 -: 8] == 8'd0) begin
            q <= q << 8;
            s <= s + 7'd8;
          end else if (!q[d2dt_pkg::PROD_W-1]) begin
            q <= q << 1;
            s <= s + 7'd1;
          end else begin
            state <= S_RND;
          end
        end
        S_RND: begin
          frac  <= fsh;
          up    <= hb && (lownz || fsh == '0 || fsh[0]);
          state <= S_FIX;
        end
        S_FIX: begin
          if (finc == (d2dt_pkg::SCALE_W + 1)'(d2dt_pkg::FRAC_SCALE) && up) begin
            frac   <= '0;
            number <= number + 32'd1;
            fnz    <= 1'b0;
          end else begin
            frac <= d2dt_pkg::SCALE_W'(finc);
            fnz  <= (finc != '0);
          end
          state <= S_BCD;
        end
        S_BCD: begin
          state <= S_CONV;
        end
        S_CONV: begin
          if (bcd_done) state <= S_PREP;
        end
        S_PREP: begin
          nf <= nf_c;
          k  <= nd_c - 4'd1;
          if (neg) state <= S_SIGN;
          else state <= S_INT;
        end
        S_SIGN: begin
          result_strobe <= 1'b1;
          character     <= d2dt_pkg::CH_MINUS;
          last          <= 1'b0;
          status        <= 1'b0;
          state         <= S_INT;
        end
        S_INT: begin
          result_strobe <= 1'b1;
          character     <= d2dt_pkg::CH_ZERO | {4'd0, dig};
          last          <= (k == 4'd0) && !fnz;
          status        <= 1'b0;
          if (k != 4'd0) k <= k - 4'd1;
          else if (fnz) state <= S_DOT;
          else state <= S_IDLE;
        end
        S_DOT: begin
          result_strobe <= 1'b1;
          character     <= d2dt_pkg::CH_DOT;
          last          <= (nf == 4'd0);
          status        <= 1'b0;
          k             <= 4'(d2dt_pkg::FRACTION_DIGITS - 1);
          if (nf == 4'd0) state <= S_IDLE;
          else state <= S_FRAC;
        end
        S_FRAC: begin
          result_strobe <= 1'b1;
          character     <= d2dt_pkg::CH_ZERO | {4'd0, dig};
          status        <= 1'b0;
          if (k == 4'(d2dt_pkg::FRACTION_DIGITS) - nf) begin
            last  <= 1'b1;
            state <= S_IDLE;
          end else begin
            last <= 1'b0;
            k    <= k - 4'd1;
          end
        end
        S_SPEC: begin
          result_strobe <= 1'b1;
          status        <= 1'b0;
          k             <= k + 4'd1;
          unique case (mode)
            M_NAN: begin
              unique case (k[1:0])
                2'd0:    character <= d2dt_pkg::CH_N;
                2'd1:    character <= d2dt_pkg::CH_A;
                default: character <= d2dt_pkg::CH_N;
              endcase
              last <= (k[1:0] == 2'd2);
              if (k[1:0] == 2'd2) state <= S_IDLE;
            end
            M_INF: begin
              unique case (k[1:0])
                2'd0:    character <= d2dt_pkg::CH_I;
                2'd1:    character <= d2dt_pkg::CH_N;
                default: character <= d2dt_pkg::CH_F;
              endcase
              last <= (k[1:0] == 2'd2);
              if (k[1:0] == 2'd2) state <= S_IDLE;
            end
            default: begin
              unique case (k[1:0])
                2'd0:    character <= d2dt_pkg::CH_MINUS;
                2'd1:    character <= d2dt_pkg::CH_I;
                2'd2:    character <= d2dt_pkg::CH_N;
                default: character <= d2dt_pkg::CH_F;
              endcase
              last <= (k[1:0] == 2'd3);
              if (k[1:0] == 2'd3) state <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/d2dt_checker.sv
// port-level checks for the decimal text formatter, bound to the top level
module d2dt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_strobe,
  input logic [7:0]  character,
  input logic        last,
  input logic        status
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  a_mid_text_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy) else $error("idle in the middle of a text");

  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status |-> last && character == 8'h00)
    else $error("flagged beat is not a lone null");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |=> !result_strobe) else $error("beat right after last");

endmodule

bind double_to_decimal_text d2dt_checker u_d2dt_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .character     (character),
  .last          (last),
  .status        (status)
);

// File: dv/tb_double_to_decimal_text.sv
// testbench for the double to decimal text formatter
`timescale 1ns / 100ps

module tb_double_to_decimal_text;

  typedef struct {
    logic [63:0] bits;
    int          idle_pct;
  } pending_beat_t;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
    logic       st;
  } text_char_t;

  localparam int QUIET_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] value_bits = '0;
  logic        busy;
  logic        result_strobe;
  logic [7:0]  character;
  logic        last;
  logic        status;

  pending_beat_t pending_values[$];
  text_char_t    expected_text[$];
  int            error_count = 0;
  int            quiet_cycles = 0;
  int            cur_idle = 0;

  double_to_decimal_text DUT (
    .clk(clk), .rst(rst), .start(start), .value_bits(value_bits), .busy(busy),
    .result_strobe(result_strobe), .character(character), .last(last), .status(status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void push_char(input logic [7:0] ch, input logic st);
    text_char_t c;
    c.ch = ch;
    c.lst = 1'b0;
    c.st = st;
    expected_text.push_back(c);
  endfunction

  function automatic void push_word(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endfunction

  function automatic void format_value(input logic [63:0] b);
    real         d;
    real         prod;
    real         rem;
    logic [31:0] whole;
    logic [31:0] frac;
    logic [7:0]  rev[$];
    bit          neg;
    bit          skip;
    int          dig;
    text_char_t  c;
    neg = 1'b0;
    if (b[62:52] == d2dt_pkg::EXP_ALL_ONES) begin
      if (b[51:0] != 0) push_word("nan");
      else if (b[63]) push_word("-inf");
      else push_word("inf");
    end else begin
      d = $bitstoreal(b);
      if (d < -2147483648.0 || d > 2147483647.0) begin
        push_char(d2dt_pkg::CH_NUL, 1'b1);
      end else begin
        if (d < 0.0) begin
          neg = 1'b1;
          d = -d;
        end
        whole = (d >= 2147483648.0) ? 32'h8000_0000 : 32'($rtoi(d));
        prod = (d - real'(whole)) * real'(d2dt_pkg::FRAC_SCALE);
        frac = 32'($rtoi(prod));
        rem = prod - real'(frac);
        if (rem > 0.5 || (rem == 0.5 && (frac == 0 || frac[0]))) begin
          frac++;
          if (frac >= d2dt_pkg::FRAC_SCALE) begin
            frac = 0;
            whole++;
          end
        end
        if (frac != 0) begin
          skip = 1'b1;
          for (int i = 0; i < d2dt_pkg::FRACTION_DIGITS; i++) begin
            dig = frac % 10;
            if (!(dig == 0 && skip)) begin
              rev.push_back(d2dt_pkg::CH_ZERO + 8'(dig));
              skip = 1'b0;
            end
            frac = frac / 10;
          end
          rev.push_back(d2dt_pkg::CH_DOT);
        end
        do begin
          rev.push_back(d2dt_pkg::CH_ZERO + 8'(whole % 10));
          whole = whole / 10;
        end while (whole > 0);
        if (neg) push_char(d2dt_pkg::CH_MINUS, 1'b0);
        while (rev.size() > 0) push_char(rev.pop_back(), 1'b0);
      end
    end
    c = expected_text.pop_back();
    c.lst = 1'b1;
    expected_text.push_back(c);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) format_value(value_bits);
      if (!start || !busy) begin
        if (pending_values.size() > 0 &&
            $urandom_range(99) >= pending_values[0].idle_pct) begin
          start <= 1'b1;
          value_bits <= pending_values[0].bits;
          void'(pending_values.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    text_char_t w;
    if (!rst && result_strobe) begin
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected beat", {character, last, status}, 0);
      end else begin
        w = expected_text.pop_front();
        if (character !== w.ch) report_mismatch("character", character, w.ch);
        if (last !== w.lst) report_mismatch("last", last, w.lst);
        if (status !== w.st) report_mismatch("status", status, w.st);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_value(input logic [63:0] b);
    pending_beat_t p;
    p.bits = b;
    p.idle_pct = cur_idle;
    pending_values.push_back(p);
  endtask

  task automatic queue_real(input real r);
    queue_value($realtobits(r));
  endtask

  task automatic queue_random(input int count);
    int  kind;
    real r;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      case (kind)
        0: queue_value({$urandom, $urandom});
        1: queue_value({1'($urandom_range(1)), 11'h7FF, 20'($urandom), $urandom});
        2: queue_real(real'($urandom_range(4095)) + real'($urandom_range(511)) / 512.0);
        3: queue_real(-(real'($urandom_range(2047)) + real'($urandom) / 4294967296.0));
        4: queue_real(real'($urandom) / 4294967296.0 / real'(1 << $urandom_range(30)));
        5: begin
          r = real'($urandom) - 2147483648.0 + real'($urandom) / 4294967296.0;
          queue_real(r);
        end
        6: queue_value({1'($urandom_range(1)), 11'($urandom_range(1034, 1090)),
                        20'($urandom), $urandom});
        default: queue_real(real'($urandom_range(99)) +
                            real'($urandom_range(99999999)) / 100000000.0);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    cur_idle = 0;
    queue_real(0.0);
    queue_value(64'h8000_0000_0000_0000);
    queue_real(1.0);
    queue_real(-1.0);
    queue_real(2147483647.0);
    queue_real(-2147483648.0);
    queue_real(2147483648.0);
    queue_real(-2147483649.0);
    queue_real(2147483647.5);
    queue_value(64'h7FF0_0000_0000_0000);
    queue_value(64'hFFF0_0000_0000_0000);
    queue_value(64'h7FF8_0000_0000_0000);
    queue_value(64'hFFF0_0000_0000_0001);
    queue_real(0.001953125);
    queue_real(3.0 * 0.001953125);
    queue_real(0.999999999);
    queue_real(-1.0e-10);
    queue_real(1.0e-9);
    queue_value(64'h0000_0000_0000_0001);
    queue_real(123.456);
    queue_real(-0.5);
    queue_real(0.000000005);
    queue_value(64'hFFFF_FFFF_FFFF_FFFF);
    queue_real(2147483647.999999999);
    queue_random(20);
    cur_idle = 60;
    queue_random(20);
    cur_idle = 36;
    queue_random(20);
    cur_idle = 0;
    queue_random(20);
    wait (pending_values.size() == 0 && !start);
    wait (expected_text.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/d2dt_pkg.sv
rtl/d2dt_bcd.sv
rtl/double_to_decimal_text.sv
rtl/d2dt_checker.sv
dv/tb_double_to_decimal_text.sv
